// ===== hdl/psa_pkg.sv =====
`timescale 1ns / 1ps
// shared types for the prime sum accumulator
// no dependencies

package psa_pkg;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_TEST = 6'b000010,
        S_DIV  = 6'b000100,
        S_STEP = 6'b001000,
        S_ADD  = 6'b010000,
        S_EMIT = 6'b100000
    } psa_state_t;

endpackage

// ===== hdl/prime_sum_accumulator.sv =====
`timescale 1ns / 1ps
// prime sum accumulator: trial-division primality test with a bit-serial divider
// depends on psa_pkg
//
// usage
// - input stream s_*: one signed value per transfer in s_tdata; zero ends a sequence
// - output stream m_*: one transfer per zero, m_tdata holds the saturated sum of the
//   primes seen since the previous zero, m_tuser flags that the sum saturated
// - s_tready is high only while the sequencer is idle; one value is tested at a time
// - negative, one and even values (except two) retire straight from idle without a divisor trial
// - an odd value n >= 3 tries odd divisors d = 3, 5, ... while d*d <= n; each divisor
//   passes through the square bound check in S_TEST, VALUE_BITS steps of the remainder
//   loop in S_DIV (one quotient bit per cycle) and the remainder test in S_STEP
// - a zero leads to S_EMIT, which sets m_tvalid once the output register is free
// - the output register holds its result while m_tready is low; the next value is
//   still taken, only a following zero waits until the pending result has gone out
// - reset clears the running sum, the overflow flag and the output valid

module prime_sum_accumulator
    import psa_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // [VALUE_BITS-1:0] value
    // output stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] m_tdata,  // [VALUE_BITS-1:0] prime_sum
    output logic                                   m_tuser    // [0] overflowed
);

    localparam int TDW = ((VALUE_BITS + 7) / 8) * 8;
    localparam int DW  = VALUE_BITS / 2 + 2;          // divisor width
    localparam int SQW = VALUE_BITS + 1;              // divisor square width
    localparam int CW  = $clog2(VALUE_BITS);
    localparam logic [VALUE_BITS-1:0] SUM_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
    localparam logic [CW-1:0] CNT_LAST = CW'(VALUE_BITS - 1);

    psa_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic [VALUE_BITS-1:0] shift_reg, shift_next;
    logic [DW-1:0]         d_reg, d_next;
    logic [SQW-1:0]        sq_reg, sq_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] sum_reg, sum_next;
    logic                  sat_reg, sat_next;
    logic                  ovalid_reg, ovalid_next;
    logic [VALUE_BITS-1:0] osum_reg, osum_next;
    logic                  oflag_reg, oflag_next;

    logic [VALUE_BITS-1:0] in_value;
    logic [DW:0]           trial;
    logic [DW:0]           trial_diff;
    logic [VALUE_BITS-1:0] sum_add;
    logic [DW+1:0]         sq_step;
    logic                  in_xfer;
    logic                  out_free;

    assign in_value   = s_tdata[VALUE_BITS-1:0];
    assign in_xfer    = s_tvalid && s_tready;
    assign out_free   = !ovalid_reg || m_tready;

    // one restoring division step: bring in the next dividend bit
    assign trial      = {rem_reg, shift_reg[VALUE_BITS-1]};
    assign trial_diff = trial - {1'b0, d_reg};

    // (d + 2)^2 = d^2 + 4d + 4
    assign sq_step    = {d_reg, 2'b00} + (DW + 2)'(4);
    assign sum_add    = sum_reg + n_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = TDW'(osum_reg);
    assign m_tuser  = oflag_reg;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        shift_next  = shift_reg;
        d_next      = d_reg;
        sq_next     = sq_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        sat_next    = sat_reg;
        ovalid_next = ovalid_reg && !m_tready;
        osum_next   = osum_reg;
        oflag_next  = oflag_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next  = in_value;
                    d_next  = DW'(3);
                    sq_next = SQW'(9);
                    if (in_value == '0)
                        state_next = S_EMIT;
                    else if (in_value[VALUE_BITS-1] || in_value == VALUE_BITS'(1))
                        state_next = S_IDLE;
                    else if (!in_value[0])
                        state_next = (in_value == VALUE_BITS'(2)) ? S_ADD : S_IDLE;
                    else
                        state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                // no divisor left below the square root: prime
                if (sq_reg > {1'b0, n_reg})
                    state_next = S_ADD;
                else
                begin
                    shift_next = n_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!trial_diff[DW])
                    rem_next = trial_diff[DW-1:0];
                else
                    rem_next = trial[DW-1:0];
                shift_next = {shift_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (rem_reg == '0)
                    state_next = S_IDLE;
                else
                begin
                    d_next     = d_reg + DW'(2);
                    sq_next    = sq_reg + SQW'(sq_step);
                    state_next = S_TEST;
                end
            end
            S_ADD:
            begin
                // both operands are below 2^(VALUE_BITS-1), so the top bit marks overflow
                if (sum_add[VALUE_BITS-1])
                begin
                    sum_next = SUM_MAX;
                    sat_next = 1'b1;
                end
                else
                    sum_next = sum_add;
                state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    osum_next   = sum_reg;
                    oflag_next  = sat_reg;
                    sum_next    = '0;
                    sat_next    = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sum_reg    <= '0;
            sat_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            sat_reg    <= sat_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        shift_reg <= shift_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        osum_reg  <= osum_next;
        oflag_reg <= oflag_next;
    end

endmodule

// ===== hdl/psa_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the prime sum accumulator, bound to the top level
// depends on psa_pkg and prime_sum_accumulator

module psa_checker
    import psa_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input logic                                   m_tuser
);

    localparam logic [VALUE_BITS-1:0] SUM_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    // a saturated sum sits at the largest positive value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[VALUE_BITS-1:0] == SUM_MAX)
        else $error("overflow flag without saturated sum");

    // the sum of primes is never negative
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[VALUE_BITS-1])
        else $error("negative prime sum");

    // a nonzero value never produces a result by itself
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[VALUE_BITS-1:0] != '0 && !m_tvalid |=> !m_tvalid)
        else $error("result without terminator");

endmodule

bind prime_sum_accumulator psa_checker #(.VALUE_BITS(VALUE_BITS)) u_psa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
